// ===== rtl/nsc_pkg.sv =====
// shared types, character codes and helpers for the nmea sentence checker
package nsc_pkg;

    typedef struct packed {
        logic        start_seen;
        logic [7:0]  length_seen;
        logic [7:0]  xor_sum;
        logic        star_seen;
        logic        hex_active;
        logic [7:0]  hex_value;
        logic [23:0] kind_chars;
        logic [4:0]  comma_count;
        logic        tail_nonempty;
    } scan_state_t;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam logic [7:0] LEN_MAX          = 8'd255;
    localparam logic [7:0] MIN_LEN_DEFAULT  = 8'd10;

    localparam logic [7:0] OFS_KIND_FIRST  = 8'd3;
    localparam logic [7:0] OFS_KIND_SECOND = 8'd4;
    localparam logic [7:0] OFS_KIND_THIRD  = 8'd5;

    localparam logic [23:0] WORD_RMC = {8'h52, 8'h4D, 8'h43};
    localparam logic [23:0] WORD_GGA = {8'h47, 8'h47, 8'h41};
    localparam logic [23:0] WORD_GSA = {8'h47, 8'h53, 8'h41};
    localparam logic [23:0] WORD_GSV = {8'h47, 8'h53, 8'h56};
    localparam logic [23:0] WORD_VTG = {8'h56, 8'h54, 8'h47};

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_RMC  = 3'd1;
    localparam logic [2:0] KIND_GGA  = 3'd2;
    localparam logic [2:0] KIND_GSA  = 3'd3;
    localparam logic [2:0] KIND_GSV  = 3'd4;
    localparam logic [2:0] KIND_VTG  = 3'd5;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            hex_digit = 5'h10;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_digit = {1'b0, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_digit = {1'b0, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_digit = {1'b0, d[3:0]};
            end
        end
    endfunction

    function automatic logic [2:0] kind_of(input logic [23:0] w);
        begin
            case (w)
                WORD_RMC: kind_of = KIND_RMC;
                WORD_GGA: kind_of = KIND_GGA;
                WORD_GSA: kind_of = KIND_GSA;
                WORD_GSV: kind_of = KIND_GSV;
                WORD_VTG: kind_of = KIND_VTG;
                default:  kind_of = KIND_NONE;
            endcase
        end
    endfunction

endpackage

// ===== rtl/nsc_scan.sv =====
// per-byte next-state logic for the sentence scan
module nsc_scan #(
    parameter int MAX_FIELDS = 20
) (
    input  logic [7:0]          text_byte,
    input  nsc_pkg::scan_state_t cur,
    output nsc_pkg::scan_state_t nxt
);

    localparam logic [4:0] FIELD_CAP = 5'(MAX_FIELDS);

    logic [4:0] digit;

    assign digit = nsc_pkg::hex_digit(text_byte);

    always_comb begin
        nxt = cur;
        if (!cur.start_seen) begin
            if (text_byte == nsc_pkg::CHAR_DOLLAR) begin
                nxt.start_seen    = 1'b1;
                nxt.length_seen   = 8'd1;
                nxt.tail_nonempty = 1'b1;
            end
        end else begin
            case (cur.length_seen)
                nsc_pkg::OFS_KIND_FIRST:  nxt.kind_chars[23:16] = text_byte;
                nsc_pkg::OFS_KIND_SECOND: nxt.kind_chars[15:8]  = text_byte;
                nsc_pkg::OFS_KIND_THIRD:  nxt.kind_chars[7:0]   = text_byte;
                default: ;
            endcase
            if (cur.length_seen != nsc_pkg::LEN_MAX) begin
                nxt.length_seen = cur.length_seen + 8'd1;
            end

            if (!cur.star_seen) begin
                if (text_byte == nsc_pkg::CHAR_STAR) begin
                    nxt.star_seen  = 1'b1;
                    nxt.hex_active = 1'b1;
                    nxt.hex_value  = 8'd0;
                end else begin
                    nxt.xor_sum = cur.xor_sum ^ text_byte;
                end
            end else if (cur.hex_active) begin
                if (!digit[4]) begin
                    nxt.hex_value = {cur.hex_value[3:0], digit[3:0]};
                end else begin
                    nxt.hex_active = 1'b0;
                end
            end

            if (cur.comma_count < FIELD_CAP) begin
                if (text_byte == nsc_pkg::CHAR_COMMA) begin
                    nxt.comma_count   = cur.comma_count + 5'd1;
                    nxt.tail_nonempty = 1'b0;
                end else begin
                    nxt.tail_nonempty = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/nmea_sentence_checker_top.sv =====
// top level of the nmea sentence checker: scan state, result register, config
// Takes one character per cycle at full rate; a line's result appears on the m_ channel
// in the cycle after its final byte is accepted, held in a one-deep output register. The
// scan state updates once per accepted byte, so s_ready stays high except when a
// final byte arrives while the previous result is still held and not being taken.
// min_sentence_length resets to 10 and should be written only while no line is in flight.
module nmea_sentence_checker_top #(
    parameter int MAX_FIELDS = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_start_found,
    output logic       m_sentence_ok,
    output logic [2:0] m_message_kind,
    output logic [4:0] m_field_count,
    output logic [7:0] m_xor_checksum,
    output logic [7:0] m_received_checksum
);

    localparam logic [4:0] FIELD_CAP = 5'(MAX_FIELDS);

    nsc_pkg::scan_state_t state_reg;
    nsc_pkg::scan_state_t state_next;
    logic [7:0] min_len_reg;
    logic       m_valid_reg;
    logic       start_reg, ok_reg;
    logic [2:0] kind_reg;
    logic [4:0] fields_reg;
    logic [7:0] xor_reg, rx_reg;

    logic       beat;
    logic       ok_next;
    logic [4:0] fields_next;

    nsc_scan #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_scan (
        .text_byte(s_text_byte),
        .cur      (state_reg),
        .nxt      (state_next)
    );

    assign s_ready = !m_valid_reg || m_ready || !s_line_end;
    assign beat    = s_valid && s_ready;

    assign ok_next = state_next.start_seen && (state_next.length_seen >= min_len_reg)
                     && state_next.star_seen && (state_next.xor_sum == state_next.hex_value);

    always_comb begin
        fields_next = 5'd0;
        if (state_next.start_seen) begin
            fields_next = state_next.comma_count;
            if (state_next.tail_nonempty && state_next.comma_count < FIELD_CAP) begin
                fields_next = state_next.comma_count + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= nsc_pkg::MIN_LEN_DEFAULT;
        end else if (cfg_we) begin
            min_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (beat) begin
            if (s_line_end) begin
                state_reg <= '0;
            end else begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat && s_line_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (beat && s_line_end) begin
            start_reg  <= state_next.start_seen;
            ok_reg     <= ok_next;
            kind_reg   <= ok_next ? nsc_pkg::kind_of(state_next.kind_chars)
                                  : nsc_pkg::KIND_NONE;
            fields_reg <= fields_next;
            xor_reg    <= state_next.xor_sum;
            rx_reg     <= state_next.hex_value;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_start_found       = start_reg;
    assign m_sentence_ok       = ok_reg;
    assign m_message_kind      = kind_reg;
    assign m_field_count       = fields_reg;
    assign m_xor_checksum      = xor_reg;
    assign m_received_checksum = rx_reg;

`ifndef SYNTHESIS
    a_ok_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ok_reg |-> start_reg)
        else $error("sentence_ok without start marker");

    a_kind_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_reg != nsc_pkg::KIND_NONE) |-> ok_reg)
        else $error("message kind on a failed sentence");

    a_no_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !start_reg |-> (fields_reg == 5'd0) && (xor_reg == 8'd0)
                                       && (rx_reg == 8'd0))
        else $error("nonzero result without start marker");

    a_last_beat_result: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && s_line_end |=> m_valid_reg)
        else $error("final beat produced no result");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && s_line_end |=> (state_reg == '0))
        else $error("scan state not cleared after final beat");
`endif

endmodule

// ===== tb/nsc_result_checker.sv =====
`timescale 1ns / 1ps
// line result predictor and comparator for the nmea sentence checker channels
module nsc_result_checker #(
    parameter int MAX_FIELDS = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_line_end,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_start_found,
    input  logic       m_sentence_ok,
    input  logic [2:0] m_message_kind,
    input  logic [4:0] m_field_count,
    input  logic [7:0] m_xor_checksum,
    input  logic [7:0] m_received_checksum,
    output int         fail_count,
    output int         lines_pending
);

    typedef struct packed {
        logic       start_found;
        logic       sentence_ok;
        logic [2:0] message_kind;
        logic [4:0] fields;
        logic [7:0] xor_checksum;
        logic [7:0] rx_checksum;
    } line_result_t;

    string        kind_names[5] = '{"RMC", "GGA", "GSA", "GSV", "VTG"};
    logic [2:0]   kind_codes[5] = '{nsc_pkg::KIND_RMC, nsc_pkg::KIND_GGA, nsc_pkg::KIND_GSA,
                                    nsc_pkg::KIND_GSV, nsc_pkg::KIND_VTG};

    nsc_pkg::scan_state_t line_scan;
    logic [7:0]   min_length;
    line_result_t expected_lines[$];
    int           errors = 0;

    // -1 for anything that is not a hex digit
    function automatic int hex_value_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic nsc_pkg::scan_state_t scan_char(input nsc_pkg::scan_state_t s,
                                                       input logic [7:0] c);
        int nib;
        if (!s.start_seen) begin
            if (c == nsc_pkg::CHAR_DOLLAR) begin
                s.start_seen    = 1'b1;
                s.length_seen   = 8'd1;
                s.tail_nonempty = 1'b1;
            end
            return s;
        end
        case (s.length_seen)
            nsc_pkg::OFS_KIND_FIRST:  s.kind_chars[23:16] = c;
            nsc_pkg::OFS_KIND_SECOND: s.kind_chars[15:8]  = c;
            nsc_pkg::OFS_KIND_THIRD:  s.kind_chars[7:0]   = c;
            default: ;
        endcase
        if (s.length_seen != nsc_pkg::LEN_MAX) s.length_seen = s.length_seen + 8'd1;
        if (!s.star_seen) begin
            if (c == nsc_pkg::CHAR_STAR) begin
                s.star_seen  = 1'b1;
                s.hex_active = 1'b1;
                s.hex_value  = 8'd0;
            end else begin
                s.xor_sum = s.xor_sum ^ c;
            end
        end else if (s.hex_active) begin
            nib = hex_value_of(c);
            if (nib >= 0) s.hex_value = {s.hex_value[3:0], 4'(nib)};
            else s.hex_active = 1'b0;
        end
        if (s.comma_count < MAX_FIELDS) begin
            if (c == nsc_pkg::CHAR_COMMA) begin
                s.comma_count   = s.comma_count + 5'd1;
                s.tail_nonempty = 1'b0;
            end else begin
                s.tail_nonempty = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic line_result_t close_line(input nsc_pkg::scan_state_t s,
                                                input logic [7:0] min_len);
        line_result_t r;
        logic [23:0]  word;
        int           fields;
        r = '0;
        if (s.start_seen) begin
            r.start_found = 1'b1;
            r.sentence_ok = (s.length_seen >= min_len) && s.star_seen &&
                            (s.xor_sum == s.hex_value);
            fields = s.comma_count;
            if (s.tail_nonempty && s.comma_count < MAX_FIELDS) fields = fields + 1;
            r.fields       = 5'(fields);
            r.xor_checksum = s.xor_sum;
            r.rx_checksum  = s.hex_value;
            if (r.sentence_ok) begin
                for (int i = 0; i < 5; i++) begin
                    word = {kind_names[i][0], kind_names[i][1], kind_names[i][2]};
                    if (s.kind_chars == word) r.message_kind = kind_codes[i];
                end
            end
        end
        return r;
    endfunction

    function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        line_result_t want;
        if (!aresetn) begin
            min_length = nsc_pkg::MIN_LEN_DEFAULT;
            line_scan  = '0;
            expected_lines.delete();
        end else begin
            if (cfg_we) min_length = cfg_wdata;
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    $error("result beat with no line pending");
                    errors++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("start_found", 8'(want.start_found), 8'(m_start_found));
                    check_field("sentence_ok", 8'(want.sentence_ok), 8'(m_sentence_ok));
                    check_field("message_kind", 8'(want.message_kind), 8'(m_message_kind));
                    check_field("m_field_count", 8'(want.fields), 8'(m_field_count));
                    check_field("xor_checksum", want.xor_checksum, m_xor_checksum);
                    check_field("m_received_checksum", want.rx_checksum,
                                m_received_checksum);
                end
            end
            if (s_valid && s_ready) begin
                line_scan = scan_char(line_scan, s_text_byte);
                if (s_line_end) begin
                    expected_lines.push_back(close_line(line_scan, min_length));
                    line_scan = '0;
                end
            end
        end
        fail_count    <= errors;
        lines_pending <= expected_lines.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// clock, reset, line stimulus and verdict for the nmea sentence checker
module tb_top;

    localparam int MAX_FIELDS  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 17;

    typedef enum {
        TAIL_UPPER, TAIL_LOWER, TAIL_WRONG, TAIL_LONG, TAIL_NONE, TAIL_BARE_STAR
    } tail_t;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [7:0] cfg_wdata   = 8'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'd0;
    logic       s_line_end  = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_start_found;
    logic       m_sentence_ok;
    logic [2:0] m_message_kind;
    logic [4:0] m_field_count;
    logic [7:0] m_xor_checksum;
    logic [7:0] m_received_checksum;

    int         fail_count;
    int         lines_pending;
    int         cycle_count = 0;
    int         bytes_sent  = 0;
    bit         no_gaps     = 1'b0;
    logic [7:0] line_buf[$];
    string      kind_names[5] = '{"RMC", "GGA", "GSA", "GSV", "VTG"};
    string      body_chars =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.-";

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    nmea_sentence_checker_top #(
        .MAX_FIELDS(MAX_FIELDS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_byte        (s_text_byte),
        .s_line_end         (s_line_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_start_found      (m_start_found),
        .m_sentence_ok      (m_sentence_ok),
        .m_message_kind     (m_message_kind),
        .m_field_count      (m_field_count),
        .m_xor_checksum     (m_xor_checksum),
        .m_received_checksum(m_received_checksum)
    );

    nsc_result_checker #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_byte        (s_text_byte),
        .s_line_end         (s_line_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_start_found      (m_start_found),
        .m_sentence_ok      (m_sentence_ok),
        .m_message_kind     (m_message_kind),
        .m_field_count      (m_field_count),
        .m_xor_checksum     (m_xor_checksum),
        .m_received_checksum(m_received_checksum),
        .fail_count         (fail_count),
        .lines_pending      (lines_pending)
    );

    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_text(input string text);
        for (int i = 0; i < text.len(); i++) line_buf.push_back(text[i]);
    endtask

    task automatic add_random_text(input int count);
        for (int i = 0; i < count; i++) line_buf.push_back(body_chars[$urandom_range(63)]);
    endtask

    task automatic close_sentence(input tail_t tail, input bit crlf);
        logic [7:0] sum;
        bit         started;
        sum     = 8'd0;
        started = 1'b0;
        foreach (line_buf[i]) begin
            if (started) sum = sum ^ line_buf[i];
            else if (line_buf[i] == nsc_pkg::CHAR_DOLLAR) started = 1'b1;
        end
        case (tail)
            TAIL_UPPER:     add_text($sformatf("*%02X", sum));
            TAIL_LOWER:     add_text($sformatf("*%02x", sum));
            TAIL_WRONG:     add_text($sformatf("*%02X", sum ^ 8'($urandom_range(1, 255))));
            TAIL_LONG:      add_text($sformatf("*%03X%02X", $urandom_range(4095), sum));
            TAIL_BARE_STAR: add_text("*");
            default: ;
        endcase
        if (crlf) begin
            line_buf.push_back(8'h0D);
            line_buf.push_back(8'h0A);
        end
    endtask

    task automatic send_beat(input logic [7:0] value, input logic last);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= value;
        s_line_end  <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_beat(line_buf[i], i == line_buf.size() - 1);
        bytes_sent += line_buf.size();
    endtask

    // waits until every pending line has its result, then lets the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lines_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_min_length(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic gen_sentence(input int field_limit, input int max_flen);
        logic [7:0] junk;
        int         pick;
        tail_t      tail;
        line_buf.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                do junk = 8'($urandom_range(1, 255)); while (junk == nsc_pkg::CHAR_DOLLAR);
                line_buf.push_back(junk);
            end
        end
        add_text($urandom_range(1) ? "$GP" : "$GN");
        pick = $urandom_range(5);
        if (pick < 5) add_text(kind_names[pick]);
        else repeat (3) line_buf.push_back(8'($urandom_range(65, 90)));
        repeat ($urandom_range(field_limit)) begin
            line_buf.push_back(nsc_pkg::CHAR_COMMA);
            add_random_text($urandom_range(max_flen));
        end
        pick = $urandom_range(99);
        if (pick < 40) tail = TAIL_UPPER;
        else if (pick < 70) tail = TAIL_LOWER;
        else if (pick < 80) tail = TAIL_WRONG;
        else if (pick < 88) tail = TAIL_LONG;
        else if (pick < 94) tail = TAIL_NONE;
        else tail = TAIL_BARE_STAR;
        close_sentence(tail, $urandom_range(1));
    endtask

    // truncated sentences, raw noise, and sentences with a stray start marker
    task automatic gen_broken();
        int keep;
        case ($urandom_range(2))
            0: begin
                gen_sentence(12, 6);
                keep = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > keep) void'(line_buf.pop_back());
            end
            1: begin
                line_buf.delete();
                repeat ($urandom_range(1, 30)) begin
                    if ($urandom_range(19) == 0) line_buf.push_back(nsc_pkg::CHAR_DOLLAR);
                    else line_buf.push_back(8'($urandom_range(1, 255)));
                end
            end
            default: begin
                gen_sentence(12, 6);
                line_buf.insert($urandom_range(1, line_buf.size()), nsc_pkg::CHAR_DOLLAR);
            end
        endcase
    endtask

    task automatic run_random(input int n_bytes, input int min_lines, input int field_limit,
                              input int max_flen);
        int first;
        int lines;
        first = bytes_sent;
        lines = 0;
        while (bytes_sent - first < n_bytes || lines < min_lines) begin
            if ($urandom_range(99) < 75) gen_sentence(field_limit, max_flen);
            else gen_broken();
            send_line();
            lines++;
        end
    endtask

    task automatic run_directed();
        foreach (kind_names[i]) begin
            line_buf.delete();
            add_text({"$GP", kind_names[i], ",123519,A,4807.038,N"});
            close_sentence(i == 1 ? TAIL_LOWER : TAIL_UPPER, bit'(i % 2));
            send_line();
        end
        // no start marker, byte extremes
        line_buf = '{8'h01, 8'hFF, 8'h7F, 8'h80};
        send_line();
        line_buf = '{nsc_pkg::CHAR_DOLLAR};
        send_line();
        // shorter than the type bytes
        line_buf.delete();
        add_text("$GP");
        send_line();
        line_buf.delete();
        add_text("$GG");
        close_sentence(TAIL_UPPER, 1'b0);
        send_line();
        // no star, empty last field
        line_buf.delete();
        add_text("$GPGGA,1,2,");
        send_line();
        // later start marker is plain text
        line_buf.delete();
        add_text("$GPGSV,$,1");
        close_sentence(TAIL_UPPER, 1'b1);
        send_line();
        line_buf.delete();
        add_text("$GPVTG,0.0,T");
        close_sentence(TAIL_LONG, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GPRMC,A");
        close_sentence(TAIL_WRONG, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GPGSA,1");
        close_sentence(TAIL_BARE_STAR, 1'b0);
        send_line();
        // one below and exactly at the default minimum length
        line_buf.delete();
        add_text("$GPVTG");
        close_sentence(TAIL_UPPER, 1'b0);
        send_line();
        line_buf.delete();
        add_text("$GPVTG,");
        close_sentence(TAIL_UPPER, 1'b0);
        send_line();
        // field count past the cap
        line_buf.delete();
        add_text("$GPGSA");
        repeat (24) add_text(",1");
        close_sentence(TAIL_UPPER, 1'b0);
        send_line();
        // length saturation, with junk ahead of the start marker
        line_buf = '{8'hFF, 8'h01};
        add_text("$GPRMC,");
        add_random_text(270);
        close_sentence(TAIL_UPPER, 1'b1);
        send_line();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        set_min_length(8'd0);
        run_random(200, 6, 12, 6);
        set_min_length(8'd255);
        run_random(250, 1, 70, 8);
        set_min_length(8'($urandom_range(1, 254)));
        no_gaps <= 1'b1;
        run_random(200, 6, 12, 6);
        no_gaps <= 1'b0;
        set_min_length(nsc_pkg::MIN_LEN_DEFAULT);
        run_random(200, 4, 24, 6);
        set_min_length(8'($urandom_range(1, 254)));
        run_random(150, 4, 12, 6);
        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
